>>> hdl/npmd_pkg.sv
package npmd_pkg;

    localparam int MAX_WALK_ELEMS = 16;

    // step kinds of the field program
    localparam logic [2:0] K_FIX   = 3'd0;
    localparam logic [2:0] K_STR   = 3'd1;
    localparam logic [2:0] K_NWN   = 3'd2;
    localparam logic [2:0] K_WNAME = 3'd3;
    localparam logic [2:0] K_NWQ   = 3'd4;
    localparam logic [2:0] K_WQ    = 3'd5;
    localparam logic [2:0] K_WQEND = 3'd6;
    localparam logic [2:0] K_END   = 3'd7;

    localparam logic [4:0] ID_VERDICT = 5'd25;

    // verdict codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_SIZE     = 3'd2;
    localparam logic [2:0] ST_BADTYPE  = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_WALK     = 3'd5;
    localparam logic [2:0] ST_TRAILING = 3'd6;

    typedef struct packed {
        logic [4:0] id;
        logic [3:0] width;
        logic [2:0] kind;
    } step_t;

    // one result item
    typedef struct packed {
        logic [4:0]  field_id;
        logic [63:0] field_value;
        logic [3:0]  element_index;
        logic        is_data_byte;
        logic        is_verdict;
        logic [2:0]  status;
    } item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic       has_field;
        item_t      field;
        logic       has_verdict;
        item_t      verdict;
    } req_t;

    function automatic step_t mk(input int id, input int w, input logic [2:0] k);
        step_t s;
        s.id = 5'(id);
        s.width = 4'(w);
        s.kind = k;
        return s;
    endfunction

    function automatic step_t prog(input logic [5:0] p);
        step_t s;
        case (p)
            6'd0:  s = mk(0, 4, K_FIX);
            6'd1:  s = mk(1, 1, K_FIX);
            6'd2:  s = mk(2, 2, K_FIX);
            6'd4:  s = mk(3, 4, K_FIX);
            6'd5:  s = mk(4, 2, K_STR);
            6'd7:  s = mk(5, 4, K_FIX);
            6'd8:  s = mk(6, 2, K_STR);
            6'd9:  s = mk(7, 2, K_STR);
            6'd11: s = mk(8, 1, K_FIX);
            6'd12: s = mk(9, 4, K_FIX);
            6'd13: s = mk(10, 8, K_FIX);
            6'd15: s = mk(13, 4, K_FIX);
            6'd16: s = mk(5, 4, K_FIX);
            6'd17: s = mk(6, 2, K_STR);
            6'd18: s = mk(7, 2, K_STR);
            6'd20: s = mk(11, 2, K_STR);
            6'd22: s = mk(12, 2, K_FIX);
            6'd24: s = mk(13, 4, K_FIX);
            6'd25: s = mk(14, 4, K_FIX);
            6'd26: s = mk(15, 2, K_NWN);
            6'd27: s = mk(16, 2, K_WNAME);
            6'd29: s = mk(17, 2, K_NWQ);
            6'd30: s = mk(8, 1, K_WQ);
            6'd31: s = mk(9, 4, K_WQ);
            6'd32: s = mk(10, 8, K_WQEND);
            6'd34: s = mk(13, 4, K_FIX);
            6'd35: s = mk(18, 1, K_FIX);
            6'd37: s = mk(8, 1, K_FIX);
            6'd38: s = mk(9, 4, K_FIX);
            6'd39: s = mk(10, 8, K_FIX);
            6'd40: s = mk(19, 4, K_FIX);
            6'd42: s = mk(13, 4, K_FIX);
            6'd43: s = mk(20, 2, K_STR);
            6'd44: s = mk(21, 4, K_FIX);
            6'd45: s = mk(18, 1, K_FIX);
            6'd47: s = mk(13, 4, K_FIX);
            6'd48: s = mk(22, 8, K_FIX);
            6'd49: s = mk(23, 4, K_FIX);
            6'd51: s = mk(23, 4, K_STR);
            6'd53: s = mk(13, 4, K_FIX);
            6'd54: s = mk(22, 8, K_FIX);
            6'd55: s = mk(23, 4, K_STR);
            6'd57: s = mk(23, 4, K_FIX);
            6'd59: s = mk(13, 4, K_FIX);
            6'd61: s = mk(13, 4, K_FIX);
            6'd62: s = mk(24, 2, K_STR);
            default: s = mk(0, 0, K_END);
        endcase
        return s;
    endfunction

    // program start per type byte, zero for an unknown type
    function automatic logic [5:0] type_start(input logic [7:0] t);
        logic [5:0] r;
        case (t)
            8'd100, 8'd101: r = 6'd4;
            8'd102: r = 6'd7;
            8'd103, 8'd105: r = 6'd11;
            8'd104: r = 6'd15;
            8'd107: r = 6'd20;
            8'd108: r = 6'd22;
            8'd109, 8'd121, 8'd123, 8'd127: r = 6'd3;
            8'd110: r = 6'd24;
            8'd111: r = 6'd29;
            8'd112: r = 6'd34;
            8'd113, 8'd115: r = 6'd37;
            8'd114: r = 6'd42;
            8'd116: r = 6'd47;
            8'd117: r = 6'd51;
            8'd118: r = 6'd53;
            8'd119: r = 6'd57;
            8'd120, 8'd122, 8'd124: r = 6'd59;
            8'd125: r = 6'd62;
            8'd126: r = 6'd61;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/npmd_front.sv
module npmd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             req_valid,
    input  logic             req_ready,
    output npmd_pkg::req_t   req
);
    import npmd_pkg::*;

    logic [5:0]  phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] seen_reg, seen_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] eleft_reg, eleft_next;
    logic [3:0]  ecnt_reg, ecnt_next;
    logic [2:0]  err_reg, err_next;

    step_t       s;
    logic [63:0] v;
    logic [3:0]  eidx;
    logic [5:0]  ph;
    logic [2:0]  st;
    req_t        r;
    logic        take;

    assign in_ready  = req_ready;
    assign req_valid = in_valid;
    assign take      = in_valid && req_ready;
    assign req       = r;

    // classify one byte and step the field program
    always_comb begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        acc_next   = acc_reg;
        dsize_next = dsize_reg;
        seen_next  = seen_reg;
        mtype_next = mtype_reg;
        rem_next   = rem_reg;
        eleft_next = eleft_reg;
        ecnt_next  = ecnt_reg;
        err_next   = err_reg;
        s = prog(phase_reg);
        v = '0;
        ph = '0;
        st = ST_OK;
        eidx = (s.kind == K_WNAME || s.kind == K_WQ || s.kind == K_WQEND) ? ecnt_reg : 4'd0;
        r = '0;

        if (seen_reg == 32'hFFFF_FFFF) err_next = ST_SIZE;
        else seen_next = seen_reg + 32'd1;

        if (err_next == ST_OK) begin
            if (s.kind == K_END) begin
                err_next = ST_TRAILING;
            end else if (rem_reg != 32'd0) begin
                r.has_field = 1'b1;
                r.field.field_id = s.id;
                r.field.field_value = {56'd0, in_byte};
                r.field.element_index = eidx;
                r.field.is_data_byte = 1'b1;
                rem_next = rem_reg - 32'd1;
                if (rem_next == 32'd0) begin
                    if (s.kind == K_WNAME) begin
                        ecnt_next = ecnt_reg + 4'd1;
                        eleft_next = eleft_reg - 16'd1;
                        if (eleft_next == 16'd0) phase_next = phase_reg + 6'd1;
                    end else begin
                        phase_next = phase_reg + 6'd1;
                    end
                end
            end else begin
                v = acc_reg | ({56'd0, in_byte} << {fbc_reg[2:0], 3'b000});
                acc_next = v;
                fbc_next = fbc_reg + 4'd1;
                if (fbc_next >= s.width) begin
                    acc_next = '0;
                    fbc_next = '0;
                    r.has_field = 1'b1;
                    r.field.field_id = s.id;
                    r.field.field_value = v;
                    r.field.element_index = eidx;
                    case (s.kind)
                        K_STR, K_WNAME: begin
                            if (v != 64'd0) begin
                                rem_next = v[31:0];
                            end else if (s.kind == K_WNAME) begin
                                ecnt_next = ecnt_reg + 4'd1;
                                eleft_next = eleft_reg - 16'd1;
                                if (eleft_next == 16'd0) phase_next = phase_reg + 6'd1;
                            end else begin
                                phase_next = phase_reg + 6'd1;
                            end
                        end
                        K_NWN, K_NWQ: begin
                            eleft_next = v[15:0];
                            ecnt_next = '0;
                            if (v > 64'(MAX_WALK_ELEMS)) err_next = ST_WALK;
                            else if (v != 64'd0) phase_next = phase_reg + 6'd1;
                            else phase_next = phase_reg + ((s.kind == K_NWN) ? 6'd2 : 6'd4);
                        end
                        K_WQEND: begin
                            ecnt_next = ecnt_reg + 4'd1;
                            eleft_next = eleft_reg - 16'd1;
                            if (eleft_next != 16'd0) phase_next = phase_reg - 6'd2;
                            else phase_next = phase_reg + 6'd1;
                        end
                        default: begin
                            if (phase_reg == 6'd0) begin
                                dsize_next = v[31:0];
                                phase_next = 6'd1;
                            end else if (phase_reg == 6'd1) begin
                                mtype_next = v[7:0];
                                if (type_start(v[7:0]) == 6'd0) err_next = ST_BADTYPE;
                                else phase_next = 6'd2;
                            end else if (phase_reg == 6'd2) begin
                                phase_next = type_start(mtype_reg);
                            end else begin
                                phase_next = phase_reg + 6'd1;
                            end
                        end
                    endcase
                end
            end
        end

        // verdict on the final byte
        ph = phase_next;
        if (seen_next < 32'd7) st = ST_SHORT;
        else if (err_next == ST_SIZE || dsize_next != seen_next) st = ST_SIZE;
        else if (err_next != ST_OK) st = err_next;
        else if (prog(ph).kind != K_END) st = ST_OVERRUN;
        else st = ST_OK;
        r.has_verdict = in_last;
        r.verdict.field_id = ID_VERDICT;
        r.verdict.field_value = {32'd0, seen_next};
        r.verdict.is_verdict = 1'b1;
        r.verdict.status = st;
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn || (take && in_last)) begin
            phase_reg <= '0;
            fbc_reg   <= '0;
            acc_reg   <= '0;
            dsize_reg <= '0;
            seen_reg  <= '0;
            mtype_reg <= '0;
            rem_reg   <= '0;
            eleft_reg <= '0;
            ecnt_reg  <= '0;
            err_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            acc_reg   <= acc_next;
            dsize_reg <= dsize_next;
            seen_reg  <= seen_next;
            mtype_reg <= mtype_next;
            rem_reg   <= rem_next;
            eleft_reg <= eleft_next;
            ecnt_reg  <= ecnt_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> hdl/npmd_queue.sv
module npmd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  npmd_pkg::req_t   wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output npmd_pkg::req_t   rd_data
);
    import npmd_pkg::*;

    req_t       mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       wr_en;
    logic       rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // two-entry request queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

endmodule

>>> hdl/npmd_back.sv
module npmd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    output logic             req_ready,
    input  npmd_pkg::req_t   req,
    output logic             out_valid,
    input  logic             out_ready,
    output npmd_pkg::item_t  out_item
);
    import npmd_pkg::*;

    // field item first, then the verdict
    logic  sent_reg;
    logic  send_field;
    logic  has_any;

    assign send_field = req.has_field && !sent_reg;
    assign has_any    = req.has_field || req.has_verdict;
    assign out_valid  = req_valid && has_any;
    assign out_item   = send_field ? req.field : req.verdict;
    assign req_ready  = !has_any || (out_ready && (!send_field || !req.has_verdict));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg <= 1'b0;
        end else if (req_valid && req_ready) begin
            sent_reg <= 1'b0;
        end else if (req_valid && out_ready && send_field) begin
            sent_reg <= 1'b1;
        end
    end

endmodule

>>> hdl/ninep_message_decoder.sv
// results: each accepted byte's request is registered in the queue ahead of the output stage
// throughput: one byte per cycle while the queue has room; a final byte that also closes a field
// gives a field item and then a verdict, and the two-entry queue between parser and output stage
// takes up that extra item, holding the input while it is full
// reset: synchronous active-low aresetn returns the parser to the size field and empties the queue
module ninep_message_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // in_byte
    input  logic         s_tlast,   // in_last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // field_id, field_value, element_index, status, zero fill
    output logic         m_tlast,   // is_verdict
    output logic         m_tuser    // is_data_byte
);
    import npmd_pkg::*;

    req_t  f_req, q_req;
    logic  f_valid, f_ready, q_valid, q_ready;
    item_t it;

    npmd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_last(s_tlast),
        .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
    );

    npmd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    npmd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_item(it)
    );

    // pack result fields
    assign m_tdata = {4'd0, it.status, it.element_index, it.field_value, it.field_id};
    assign m_tlast = it.is_verdict;
    assign m_tuser = it.is_data_byte;

endmodule

>>> hdl/npmd_checker.sv
module npmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    import npmd_pkg::*;

    // a verdict item is never a data byte
    a_verdict_not_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser) else $error("verdict flagged as data");

    // non-verdict items carry zero status
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[75:73] == ST_OK) else $error("status on field item");

    // verdict carries the verdict id
    a_verdict_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[4:0] == ID_VERDICT) else $error("bad verdict id");

    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");

endmodule

bind ninep_message_decoder npmd_checker u_npmd_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
);
